/* hdl/mrpp_pkg.sv */
// Shared types and constants for the MQTT receive packet parser.
// No dependencies; imported by mrpp_step and the top level.
package mrpp_pkg;

  // Remaining-length digits allowed before the length is malformed (1 to 4)
  localparam int MAX_LENGTH_DIGITS = 4;

  // Control packet types with a classified body
  localparam logic [3:0] PT_CONNACK  = 4'd2;
  localparam logic [3:0] PT_PUBLISH  = 4'd3;
  localparam logic [3:0] PT_PUBACK   = 4'd4;
  localparam logic [3:0] PT_PUBREC   = 4'd5;
  localparam logic [3:0] PT_PUBREL   = 4'd6;
  localparam logic [3:0] PT_PUBCOMP  = 4'd7;
  localparam logic [3:0] PT_SUBACK   = 4'd9;
  localparam logic [3:0] PT_UNSUBACK = 4'd11;

  localparam logic [1:0] QOS_0       = 2'd0;
  localparam logic [1:0] QOS_INVALID = 2'd3;
  localparam logic [7:0] RC_MAX      = 8'd5;
  localparam logic [2:0] RC_FAILED   = 3'd6;

  // Parser phase; its code is also the role of the byte seen in that phase
  typedef enum logic [3:0] {
    PH_HDR     = 4'd0,
    PH_LEN     = 4'd1,
    PH_TLEN_HI = 4'd2,
    PH_TLEN_LO = 4'd3,
    PH_TOPIC   = 4'd4,
    PH_ID_HI   = 4'd5,
    PH_ID_LO   = 4'd6,
    PH_PAYLOAD = 4'd7,
    PH_ACKF    = 4'd8,
    PH_RET     = 4'd9,
    PH_SUB     = 4'd10,
    PH_OTHER   = 4'd11
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_LENGTH = 2'd1,
    ERR_QOS    = 2'd2,
    ERR_SHORT  = 2'd3
  } err_t;

  // Parser state carried from byte to byte
  typedef struct packed {
    phase_t      phase;
    logic [3:0]  header_type;
    logic [3:0]  header_flags;
    logic [27:0] length_accum;
    logic [1:0]  digit_count;
    logic [27:0] body_left;
    logic [15:0] topic_len;
    logic [15:0] topic_left;
    logic [15:0] packet_id;
    err_t        err;
    logic        session;
  } state_t;

  // One tagged byte
  typedef struct packed {
    logic [3:0]  byte_role;
    logic [7:0]  data_value;
    logic [3:0]  packet_type;
    logic [3:0]  packet_flags;
    logic [27:0] remaining_length;
    logic [15:0] topic_length;
    logic [15:0] packet_id;
    logic        session_present;
    logic [2:0]  return_code;
    logic [1:0]  error;
    logic        packet_end;
  } result_t;

endpackage

/* hdl/mqtt_receive_packet_parser.sv */
// Top level of the MQTT receive packet parser: state register and output skid buffer.
// Depends on mrpp_pkg and mrpp_step.
//
//   channel | signals                         | payload
//   --------+---------------------------------+------------------------------------------
//   in      | in_valid, in_stall (driven out) | data_byte
//   out     | out_valid, out_stall (driven in)| byte_role, data_value, packet_type, ...
//
// One byte per cycle while the output does not stall; each byte's tag is registered.
// The per-byte state update is a single pass through mrpp_step into the state register.
// rst (synchronous) returns the parser to expecting a fixed header and empties the output.
// A stalled output keeps its tag; one more byte goes into the skid register, after
// which in_stall rises until the output drains.
module mqtt_receive_packet_parser
  import mrpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  byte_role,
  output logic [7:0]  data_value,
  output logic [3:0]  packet_type,
  output logic [3:0]  packet_flags,
  output logic [27:0] remaining_length,
  output logic [15:0] topic_length,
  output logic [15:0] packet_id,
  output logic        session_present,
  output logic [2:0]  return_code,
  output logic [1:0]  error,
  output logic        packet_end
);

  state_t  state;
  state_t  state_next;
  result_t res;
  result_t main_res;
  result_t skid_res;
  logic    skid_valid;
  logic    accept;
  logic    main_free;

  mrpp_step u_step (
    .cur       (state),
    .data_byte (data_byte),
    .nxt       (state_next),
    .res       (res)
  );

  assign in_stall  = skid_valid;
  assign accept    = in_valid && !skid_valid;
  assign main_free = !out_valid || !out_stall;

  // Parser state advances on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Output and skid valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Output and skid payload
  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid) main_res <= skid_res;
      else if (accept) main_res <= res;
    end else if (accept) begin
      skid_res <= res;
    end
  end

  assign byte_role        = main_res.byte_role;
  assign data_value       = main_res.data_value;
  assign packet_type      = main_res.packet_type;
  assign packet_flags     = main_res.packet_flags;
  assign remaining_length = main_res.remaining_length;
  assign topic_length     = main_res.topic_length;
  assign packet_id        = main_res.packet_id;
  assign session_present  = main_res.session_present;
  assign return_code      = main_res.return_code;
  assign error            = main_res.error;
  assign packet_end       = main_res.packet_end;

endmodule

/* hdl/mrpp_step.sv */
// Per-byte next-state and tag logic of the MQTT receive packet parser.
// Purely combinational; uses mrpp_pkg.
module mrpp_step
  import mrpp_pkg::*;
(
  input  state_t     cur,
  input  logic [7:0] data_byte,
  output state_t     nxt,
  output result_t    res
);

  // First body phase for a packet type
  function automatic phase_t body_start(input logic [3:0] t);
    phase_t p;
    case (t)
      PT_PUBLISH: p = PH_TLEN_HI;
      PT_CONNACK: p = PH_ACKF;
      PT_PUBACK, PT_PUBREC, PT_PUBREL, PT_PUBCOMP, PT_SUBACK, PT_UNSUBACK: p = PH_ID_HI;
      default:    p = PH_OTHER;
    endcase
    return p;
  endfunction

  function automatic phase_t after_id(input logic [3:0] t);
    phase_t p;
    if (t == PT_PUBLISH) p = PH_PAYLOAD;
    else if (t == PT_SUBACK) p = PH_SUB;
    else p = PH_OTHER;
    return p;
  endfunction

  // Phases whose fields are still owed when the packet ends
  function automatic logic needs_more(input phase_t p);
    return (p == PH_TLEN_HI) || (p == PH_TLEN_LO) || (p == PH_TOPIC) ||
           (p == PH_ID_HI) || (p == PH_ID_LO) || (p == PH_ACKF) || (p == PH_RET);
  endfunction

  localparam logic [2:0] LastDigit = 3'(MAX_LENGTH_DIGITS);

  logic [27:0] digit_bits;
  logic [27:0] acc;
  logic [15:0] tl;
  logic [15:0] tl_dec;
  logic [27:0] bl_dec;
  logic [1:0]  qos;
  logic        topic_done;
  logic        finish;
  logic        pend;
  logic [2:0]  retcode;

  always_comb begin
    nxt        = cur;
    retcode    = '0;
    pend       = 1'b0;
    finish     = 1'b0;
    topic_done = 1'b0;
    qos        = cur.header_flags[2:1];
    tl         = {cur.topic_len[15:8], data_byte};
    tl_dec     = (cur.topic_left != '0) ? cur.topic_left - 16'd1 : cur.topic_left;
    bl_dec     = (cur.body_left != '0) ? cur.body_left - 28'd1 : cur.body_left;

    // 7-bit length digit placed by its position
    case (cur.digit_count)
      2'd0:    digit_bits = {21'd0, data_byte[6:0]};
      2'd1:    digit_bits = {14'd0, data_byte[6:0], 7'd0};
      2'd2:    digit_bits = {7'd0, data_byte[6:0], 14'd0};
      default: digit_bits = {data_byte[6:0], 21'd0};
    endcase
    acc = cur.length_accum | digit_bits;

    case (cur.phase)
      PH_HDR: begin
        nxt              = '0;
        nxt.header_type  = data_byte[7:4];
        nxt.header_flags = data_byte[3:0];
        nxt.phase        = PH_LEN;
      end
      PH_LEN: begin
        nxt.length_accum = acc;
        if (!data_byte[7]) begin
          nxt.body_left = acc;
          nxt.phase     = body_start(cur.header_type);
          if (acc == '0) begin
            pend   = 1'b1;
            finish = 1'b1;
          end
        end else if ({1'b0, cur.digit_count} + 3'd1 >= LastDigit) begin
          // continuation on the last allowed digit: malformed, restart
          nxt.err   = ERR_LENGTH;
          pend      = 1'b1;
          nxt.phase = PH_HDR;
        end else begin
          nxt.digit_count = cur.digit_count + 2'd1;
        end
      end
      default: begin
        case (cur.phase)
          PH_TLEN_HI: begin
            nxt.topic_len = {data_byte, 8'd0};
            nxt.phase     = PH_TLEN_LO;
          end
          PH_TLEN_LO: begin
            nxt.topic_len  = tl;
            nxt.topic_left = tl;
            if (tl == '0) topic_done = 1'b1;
            else nxt.phase = PH_TOPIC;
          end
          PH_TOPIC: begin
            nxt.topic_left = tl_dec;
            if (tl_dec == '0) topic_done = 1'b1;
          end
          PH_ID_HI: begin
            nxt.packet_id = {data_byte, 8'd0};
            nxt.phase     = PH_ID_LO;
          end
          PH_ID_LO: begin
            nxt.packet_id = {cur.packet_id[15:8], data_byte};
            nxt.phase     = after_id(cur.header_type);
          end
          PH_ACKF: begin
            nxt.session = data_byte[0];
            nxt.phase   = PH_RET;
          end
          PH_RET: begin
            retcode   = (data_byte > RC_MAX) ? RC_FAILED : data_byte[2:0];
            nxt.phase = PH_OTHER;
          end
          default: begin
          end
        endcase
        // topic complete: bad QoS, packet id, or straight to payload
        if (topic_done) begin
          if (qos == QOS_INVALID) begin
            nxt.err   = ERR_QOS;
            nxt.phase = PH_OTHER;
          end else if (qos == QOS_0) begin
            nxt.phase = PH_PAYLOAD;
          end else begin
            nxt.phase = PH_ID_HI;
          end
        end
        nxt.body_left = bl_dec;
        if (bl_dec == '0) begin
          pend   = 1'b1;
          finish = 1'b1;
        end
      end
    endcase

    // end of packet: flag missing fields, expect a new header
    if (finish) begin
      if (needs_more(nxt.phase) && (nxt.err == ERR_NONE)) nxt.err = ERR_SHORT;
      nxt.phase = PH_HDR;
    end
  end

  // Tag for this byte
  always_comb begin
    res.byte_role        = cur.phase;
    res.data_value       = data_byte;
    res.packet_type      = nxt.header_type;
    res.packet_flags     = nxt.header_flags;
    res.remaining_length = nxt.length_accum;
    res.topic_length     = nxt.topic_len;
    res.packet_id        = nxt.packet_id;
    res.session_present  = nxt.session;
    res.return_code      = retcode;
    res.error            = nxt.err;
    res.packet_end       = pend;
  end

endmodule
